>>> src/sslc_pkg.sv
// Shared types and constants for the screen-space LOD classifier.
`default_nettype none
package sslc_pkg;

  // Level-of-detail codes on the lod_level output.
  typedef enum logic [1:0] {
    LOD_FULL     = 2'd0,
    LOD_IMPOSTOR = 2'd1,
    LOD_POINT    = 2'd2
  } lod_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_PIXELS_PER_UNIT    = 2'd0,
    REG_THRESHOLD_FULL     = 2'd1,
    REG_THRESHOLD_IMPOSTOR = 2'd2,
    REG_BASE_MIN_PIXEL     = 2'd3
  } cfg_reg_e;

  localparam logic [31:0] SAT32             = 32'hFFFF_FFFF;
  localparam logic [31:0] RST_PIXELS_PER_UNIT = 32'd65536;
  localparam logic [31:0] RST_THRESHOLD_FULL  = 32'd6553600;
  localparam logic [31:0] RST_THRESHOLD_IMP   = 32'd655360;
  localparam logic [31:0] RST_BASE_MIN_PIXEL  = 32'd65536;

  // Quotient width and divisor width of the divider lanes.
  localparam int unsigned QW = 32;
  localparam int unsigned DW = 33;

  // Data that rides alongside the square root pipeline.
  typedef struct packed {
    logic [31:0] radius;
    logic [15:0] imp;
    logic [63:0] rk;
    logic [47:0] bi;
  } sqrt_side_t;

  // Data that rides alongside the divider pipeline.
  typedef struct packed {
    logic        proj_sat;
    logic        minw_sat;
    logic        minw_zero;
    logic [31:0] min_px;
    logic [31:0] radius;
  } div_side_t;

endpackage
`default_nettype wire

>>> src/sslc_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module sslc_sqrt #(
  parameter int unsigned SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [63:0]   rad_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [31:0]        root_o,
  output logic [SW-1:0]      side_o
);

  logic          v_q    [32];
  logic [63:0]   n_q    [32];
  logic [31:0]   root_q [32];
  logic [33:0]   rem_q  [32];
  logic [SW-1:0] side_q [32];

  for (genvar k = 0; k < 32; k++) begin : g_stage
    logic          in_v;
    logic [63:0]   in_n;
    logic [31:0]   in_root;
    logic [33:0]   in_rem;
    logic [SW-1:0] in_side;
    logic [35:0]   rem_sh;
    logic [35:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign in_v    = valid_i;
      assign in_n    = rad_i;
      assign in_root = '0;
      assign in_rem  = '0;
      assign in_side = side_i;
    end else begin : g_next
      assign in_v    = v_q[k-1];
      assign in_n    = n_q[k-1];
      assign in_root = root_q[k-1];
      assign in_rem  = rem_q[k-1];
      assign in_side = side_q[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_sh = {in_rem, in_n[63:62]};
    assign trial  = {2'b00, in_root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]    <= {in_n[61:0], 2'b00};
        root_q[k] <= {in_root[30:0], ge};
        rem_q[k]  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
        side_q[k] <= in_side;
      end
    end
  end

  assign valid_o = v_q[31];
  assign root_o  = root_q[31];
  assign side_o  = side_q[31];

endmodule
`default_nettype wire

>>> src/sslc_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module sslc_div #(
  parameter int unsigned SW = 1
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire logic [1:0][sslc_pkg::DW-1:0]   rem_i,
  input  wire logic [1:0][sslc_pkg::QW-1:0]   low_i,
  input  wire logic [1:0][sslc_pkg::DW-1:0]   div_i,
  input  wire logic [SW-1:0]                  side_i,
  output logic                                valid_o,
  output logic [1:0][sslc_pkg::QW-1:0]        quo_o,
  output logic [SW-1:0]                       side_o
);
  import sslc_pkg::*;

  logic                v_q    [QW];
  logic [1:0][DW-1:0]  rem_q  [QW];
  logic [1:0][QW-1:0]  low_q  [QW];
  logic [1:0][DW-1:0]  div_q  [QW];
  logic [SW-1:0]       side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic               in_v;
    logic [1:0][DW-1:0] in_rem;
    logic [1:0][QW-1:0] in_low;
    logic [1:0][DW-1:0] in_div;
    logic [SW-1:0]      in_side;
    logic [1:0][DW-1:0] rem_d;
    logic [1:0][QW-1:0] low_d;

    if (k == 0) begin : g_first
      assign in_v    = valid_i;
      assign in_rem  = rem_i;
      assign in_low  = low_i;
      assign in_div  = div_i;
      assign in_side = side_i;
    end else begin : g_next
      assign in_v    = v_q[k-1];
      assign in_rem  = rem_q[k-1];
      assign in_low  = low_q[k-1];
      assign in_div  = div_q[k-1];
      assign in_side = side_q[k-1];
    end

    // Shift in the next dividend bit and subtract where the divisor fits.
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DW:0] r2;
      logic        ge;
      assign r2 = {in_rem[l], in_low[l][QW-1]};
      assign ge = (r2 >= {1'b0, in_div[l]});
      assign rem_d[l] = ge ? DW'(r2 - {1'b0, in_div[l]}) : r2[DW-1:0];
      assign low_d[l] = {in_low[l][QW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        low_q[k]  <= low_d;
        div_q[k]  <= in_div;
        side_q[k] <= in_side;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = low_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule
`default_nettype wire

>>> src/screen_space_lod_classifier_top.sv
// Top level of the screen-space LOD classifier pipeline.
//
// Each word carries one object's camera-relative position, world radius and
// importance, and yields one word with its level of detail, on-screen pixel
// radius and enlarged render radius. The pipeline takes one word per clock and
// holds up to 71 words in flight: three stages of squaring, a 32-stage square
// root, three multiply stages, a 32-stage two-lane divider and an output
// register. When the output is stalled the whole pipeline holds, and in_stall_o
// rises only while a finished word is waiting and stalled. The user must write
// registers through the cfg port only while no word is in flight; the block
// itself does not enforce this.
`default_nettype none
module screen_space_lod_classifier_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] pos_x_i,
  input  wire logic [31:0] pos_y_i,
  input  wire logic [31:0] pos_z_i,
  input  wire logic [31:0] obj_radius_i,
  input  wire logic [15:0] importance_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       lod_level_o,
  output logic [31:0]      pixel_radius_o,
  output logic [31:0]      render_radius_o
);
  import sslc_pkg::*;

  logic [31:0] ppu_q, thr_full_q, thr_imp_q, base_min_q;
  logic        en;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppu_q      <= RST_PIXELS_PER_UNIT;
      thr_full_q <= RST_THRESHOLD_FULL;
      thr_imp_q  <= RST_THRESHOLD_IMP;
      base_min_q <= RST_BASE_MIN_PIXEL;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PIXELS_PER_UNIT:    ppu_q      <= cfg_data_i;
        REG_THRESHOLD_FULL:     thr_full_q <= cfg_data_i;
        REG_THRESHOLD_IMPOSTOR: thr_imp_q  <= cfg_data_i;
        REG_BASE_MIN_PIXEL:     base_min_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a finished word is held by a stall.
  logic out_v_q;
  assign en         = !out_v_q || !out_stall_i;
  assign in_stall_o = !en;

  // Stage 1: absolute values.
  logic        v1_q, v2_q, v3_q;
  logic [31:0] ax_q, ay_q, az_q, r1_q, r2_q, r3_q;
  logic [15:0] i1_q, i2_q, i3_q;
  logic [63:0] sx_q, sy_q, sz_q, sum_q, rk_q;
  logic [47:0] bi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q  <= pos_x_i[31] ? 32'(-pos_x_i) : pos_x_i;
      ay_q  <= pos_y_i[31] ? 32'(-pos_y_i) : pos_y_i;
      az_q  <= pos_z_i[31] ? 32'(-pos_z_i) : pos_z_i;
      r1_q  <= obj_radius_i;
      i1_q  <= importance_i;
      // Stage 2: squares.
      sx_q  <= 64'(ax_q) * 64'(ax_q);
      sy_q  <= 64'(ay_q) * 64'(ay_q);
      sz_q  <= 64'(az_q) * 64'(az_q);
      r2_q  <= r1_q;
      i2_q  <= i1_q;
      // Stage 3: sum of squares, radius times scale, base times importance.
      sum_q <= sx_q + sy_q + sz_q;
      rk_q  <= 64'(r2_q) * 64'(ppu_q);
      bi_q  <= 48'(base_min_q) * 48'(i2_q);
      r3_q  <= r2_q;
      i3_q  <= i2_q;
    end
  end

  // Distance by square root.
  sqrt_side_t sq_side_in, sq_side_out;
  logic       sq_v;
  logic [31:0] root_dist;

  assign sq_side_in = '{radius: r3_q, imp: i3_q, rk: rk_q, bi: bi_q};

  sslc_sqrt #(.SW($bits(sqrt_side_t))) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .rad_i   (sum_q),
    .side_i  (sq_side_in),
    .valid_o (sq_v),
    .root_o  (root_dist),
    .side_o  (sq_side_out)
  );

  // Stage 4: full projection numerator and distance times base.
  logic        v4_q, v5_q, v6_q;
  logic [79:0] rki_q, rki5_q;
  logic [63:0] db_q;
  logic [31:0] dc_q, dc5_q, r4_q, r5_q, r6_q, minpx5_q, minpx6_q;
  logic [15:0] i4_q;
  logic [47:0] bi4_q;
  logic [79:0] dbi_q;
  logic        psat5_q;
  logic [1:0][DW-1:0] rem6_q, div6_q;
  logic [1:0][QW-1:0] low6_q;
  logic        psat6_q, msat6_q, mzero6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v4_q <= sq_v;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rki_q    <= 80'(sq_side_out.rk) * 80'(sq_side_out.imp);
      db_q     <= 64'(root_dist) * 64'(base_min_q);
      dc_q     <= (root_dist == '0) ? 32'd1 : root_dist;
      r4_q     <= sq_side_out.radius;
      i4_q     <= sq_side_out.imp;
      bi4_q    <= sq_side_out.bi;
      // Stage 5: second product of the minimum world radius, projection overflow.
      dbi_q    <= 80'(db_q) * 80'(i4_q);
      psat5_q  <= (rki_q[79:48] >= dc_q);
      rki5_q   <= rki_q;
      dc5_q    <= dc_q;
      r5_q     <= r4_q;
      minpx5_q <= (bi4_q[47:40] != '0) ? SAT32 : bi4_q[39:8];
      // Stage 6: divider operands and the minimum world radius overflow.
      rem6_q[0] <= {1'b0, rki5_q[79:48]};
      low6_q[0] <= rki5_q[47:16];
      div6_q[0] <= {1'b0, dc5_q};
      rem6_q[1] <= dbi_q[64:32];
      low6_q[1] <= dbi_q[31:0];
      div6_q[1] <= {ppu_q, 1'b0};
      psat6_q   <= psat5_q;
      msat6_q   <= (dbi_q[79:32] >= {15'd0, ppu_q, 1'b0});
      mzero6_q  <= (ppu_q == '0) && (dbi_q == '0);
      minpx6_q  <= minpx5_q;
      r6_q      <= r5_q;
    end
  end

  // Both divisions share one pipeline.
  div_side_t dv_side_in, dv_side_out;
  logic      dv_v;
  logic [1:0][QW-1:0] quo;

  assign dv_side_in = '{proj_sat: psat6_q, minw_sat: msat6_q, minw_zero: mzero6_q,
                        min_px: minpx6_q, radius: r6_q};

  sslc_div #(.SW($bits(div_side_t))) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .rem_i   (rem6_q),
    .low_i   (low6_q),
    .div_i   (div6_q),
    .side_i  (dv_side_in),
    .valid_o (dv_v),
    .quo_o   (quo),
    .side_o  (dv_side_out)
  );

  // Final selection: saturation, floors and level of detail.
  logic [31:0] proj, pix_d, minw, rend_d;
  lod_e        lod_d;

  always_comb begin
    proj   = dv_side_out.proj_sat ? SAT32 : quo[0];
    pix_d  = (proj > dv_side_out.min_px) ? proj : dv_side_out.min_px;
    minw   = dv_side_out.minw_zero ? 32'd0 : (dv_side_out.minw_sat ? SAT32 : quo[1]);
    rend_d = (dv_side_out.radius > minw) ? dv_side_out.radius : minw;
    priority if (pix_d >= thr_full_q) begin
      lod_d = LOD_FULL;
    end else if (pix_d >= thr_imp_q) begin
      lod_d = LOD_IMPOSTOR;
    end else begin
      lod_d = LOD_POINT;
    end
  end

  logic [1:0]  lod_q;
  logic [31:0] pix_q, rend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lod_q  <= lod_d;
      pix_q  <= pix_d;
      rend_q <= rend_d;
    end
  end

  assign out_valid_o     = out_v_q;
  assign lod_level_o     = lod_q;
  assign pixel_radius_o  = pix_q;
  assign render_radius_o = rend_q;

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the screen-space LOD classifier pipeline.
`default_nettype none
module tb_top;
  import sslc_pkg::*;

  localparam int unsigned PIPE_LATENCY = 71;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] pos_x_i, pos_y_i, pos_z_i, obj_radius_i;
  logic [15:0] importance_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  lod_level_o;
  logic [31:0] pixel_radius_o, render_radius_o;

  typedef struct packed {
    lod_e        lod;
    logic [31:0] pix;
    logic [31:0] rend;
  } lod_word_t;

  // Shadow copy of the configuration registers.
  logic [31:0] k_q, thr_full_q, thr_imp_q, base_min_q;

  lod_word_t   lod_expected_q[$];
  int          mismatch_count;
  int          idle_cycles;
  bit          sender_idles;
  bit          receiver_idles;
  bit          hold_off;

  screen_space_lod_classifier_top u_dut (.*);

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Integer square root of a value up to 96 bits, rounded down.
  function automatic logic [63:0] floor_sqrt(logic [95:0] n);
    logic [63:0] root;
    logic [127:0] trial;
    root = '0;
    for (int b = 48; b >= 0; b--) begin
      trial = {64'd0, root | (64'd1 << b)};
      if (trial * trial <= {32'd0, n}) root = trial[63:0];
    end
    return root;
  endfunction

  // Expected classification of one object under the current registers.
  function automatic lod_word_t classify_object(logic [31:0] px, logic [31:0] py,
                                                logic [31:0] pz, logic [31:0] rad,
                                                logic [15:0] imp);
    logic [31:0]  ax, ay, az;
    logic [95:0]  dist_sq;
    logic [63:0]  root_dist, dist_c;
    logic [127:0] num, quo;
    logic [63:0]  bi;
    logic [31:0]  proj, min_px, minw;
    lod_word_t    w;
    ax = px[31] ? -px : px;
    ay = py[31] ? -py : py;
    az = pz[31] ? -pz : pz;
    dist_sq = 96'(ax) * ax + 96'(ay) * ay + 96'(az) * az;
    root_dist = floor_sqrt(dist_sq);
    dist_c = (root_dist == 0) ? 64'd1 : root_dist;
    num = 128'(rad) * k_q * imp;
    quo = num / (128'(dist_c) << 16);
    proj = (quo > 128'(SAT32)) ? SAT32 : quo[31:0];
    bi = 64'(base_min_q) * imp;
    min_px = ((bi >> 8) > 64'(SAT32)) ? SAT32 : 32'(bi >> 8);
    w.pix = (proj > min_px) ? proj : min_px;
    if (k_q == 0) begin
      minw = (bi != 0 && root_dist != 0) ? SAT32 : 32'd0;
    end else begin
      quo = (128'(bi) * root_dist) / (128'(k_q) << 1);
      minw = (quo > 128'(SAT32)) ? SAT32 : quo[31:0];
    end
    w.rend = (rad > minw) ? rad : minw;
    if (w.pix >= thr_full_q) w.lod = LOD_FULL;
    else if (w.pix >= thr_imp_q) w.lod = LOD_IMPOSTOR;
    else w.lod = LOD_POINT;
    return w;
  endfunction

  // Receiver stall: random, or held high during a hold-off stretch.
  always @(posedge clk_i) begin
    out_stall_i <= hold_off || (receiver_idles && $urandom_range(99) < 36);
  end

  // Result checker.
  always @(posedge clk_i) begin
    lod_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lod_expected_q.size() == 0) begin
        $display("%0t: unexpected word lod=%0d pix=%h rend=%h", $time,
                 lod_level_o, pixel_radius_o, render_radius_o);
        mismatch_count++;
      end else begin
        e = lod_expected_q.pop_front();
        if (lod_level_o !== e.lod) begin
          $display("%0t: lod_level expected %0d actual %0d", $time, e.lod, lod_level_o);
          mismatch_count++;
        end
        if (pixel_radius_o !== e.pix) begin
          $display("%0t: pixel_radius expected %h actual %h", $time, e.pix, pixel_radius_o);
          mismatch_count++;
        end
        if (render_radius_o !== e.rend) begin
          $display("%0t: render_radius expected %h actual %h", $time, e.rend,
                   render_radius_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("screen_space_lod_classifier_top verification failed");
      $finish;
    end
  end

  // Sends one object and records its expected result on acceptance.
  task automatic send_object(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [31:0] rad, logic [15:0] imp);
    while (sender_idles && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pos_x_i      <= px;
    pos_y_i      <= py;
    pos_z_i      <= pz;
    obj_radius_i <= rad;
    importance_i <= imp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    lod_expected_q.push_back(classify_object(px, py, pz, rad, imp));
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (lod_expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register writes happen only with the pipeline empty.
  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_PIXELS_PER_UNIT:    k_q = val;
      REG_THRESHOLD_FULL:     thr_full_q = val;
      REG_THRESHOLD_IMPOSTOR: thr_imp_q = val;
      default:                base_min_q = val;
    endcase
    @(posedge clk_i);
  endtask

  // Random coordinate: mostly moderate, sometimes full width.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(200)) - 100);
      default: return 32'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  function automatic logic [31:0] rand_radius();
    return $urandom_range(1) ? $urandom : 32'($urandom_range(65535));
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++)
      send_object(rand_coord(), rand_coord(), rand_coord(), rand_radius(),
                  $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(512)));
  endtask

  // Field extremes, origin object and zero importance at reset values.
  task automatic test_directed_extremes();
    send_object(0, 0, 0, 32'h100, 16'h100);
    send_object(0, 0, 0, 0, 0);
    send_object(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, SAT32, 16'hFFFF);
    send_object(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, SAT32, 16'hFFFF);
    send_object(32'hFFFF_FFFF, 0, 0, 32'h100, 16'h100);
    send_object(3, 4, 0, 32'h500, 16'h100);
    send_object(0, 0, 1000, 32'h6400, 16'h100);
    send_object(0, 10, 0, 32'h100, 16'h100);
    send_object(0, 0, 10, 32'h1000, 16'h100);
    send_object(5, 5, 5, 0, 16'hFFFF);
    send_object(1, 0, 0, SAT32, 16'h0001);
    drain_pipeline();
  endtask

  // Zero pixels-per-unit, with and without the minimum size term.
  task automatic test_zero_scale();
    write_reg(REG_PIXELS_PER_UNIT, 0);
    send_object(0, 0, 0, 32'h100, 16'h100);
    send_object(7, 0, 0, 32'h100, 16'h100);
    send_object(7, 0, 0, 32'h100, 0);
    drain_pipeline();
    write_reg(REG_BASE_MIN_PIXEL, 0);
    send_object(7, 0, 0, 32'h100, 16'h100);
    send_random(20);
    drain_pipeline();
  endtask

  // Crossed thresholds and all-ones registers.
  task automatic test_crossed_thresholds();
    write_reg(REG_PIXELS_PER_UNIT, SAT32);
    write_reg(REG_BASE_MIN_PIXEL, SAT32);
    write_reg(REG_THRESHOLD_FULL, 32'h0010_0000);
    write_reg(REG_THRESHOLD_IMPOSTOR, 32'h0100_0000);
    send_random(60);
    drain_pipeline();
    write_reg(REG_THRESHOLD_FULL, SAT32);
    write_reg(REG_THRESHOLD_IMPOSTOR, 0);
    send_random(40);
    drain_pipeline();
  endtask

  // Random settings with random stimulus per phase.
  task automatic test_random_phases();
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_PIXELS_PER_UNIT, $urandom_range(1) ? $urandom : $urandom_range(1 << 22));
      write_reg(REG_THRESHOLD_FULL, $urandom_range(1 << 26));
      write_reg(REG_THRESHOLD_IMPOSTOR, $urandom_range(1 << 22));
      write_reg(REG_BASE_MIN_PIXEL, $urandom_range(1) ? $urandom : $urandom_range(1 << 18));
      send_random(130);
      drain_pipeline();
    end
  endtask

  // Long receiver hold-off so the pipeline fills and stalls its input.
  task automatic test_backpressure();
    write_reg(REG_PIXELS_PER_UNIT, RST_PIXELS_PER_UNIT);
    write_reg(REG_THRESHOLD_FULL, RST_THRESHOLD_FULL);
    write_reg(REG_THRESHOLD_IMPOSTOR, RST_THRESHOLD_IMP);
    write_reg(REG_BASE_MIN_PIXEL, RST_BASE_MIN_PIXEL);
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      send_random(120);
    join
    drain_pipeline();
  endtask

  // Full-rate stretch with no idling on either side.
  task automatic test_full_rate();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    send_random(150);
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    drain_pipeline();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_PIXELS_PER_UNIT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    pos_x_i = '0;
    pos_y_i = '0;
    pos_z_i = '0;
    obj_radius_i = '0;
    importance_i = '0;
    mismatch_count = 0;
    idle_cycles = 0;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    hold_off = 1'b0;
    k_q = RST_PIXELS_PER_UNIT;
    thr_full_q = RST_THRESHOLD_FULL;
    thr_imp_q = RST_THRESHOLD_IMP;
    base_min_q = RST_BASE_MIN_PIXEL;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_zero_scale();
    test_crossed_thresholds();
    test_random_phases();
    test_backpressure();
    test_full_rate();
    repeat (PIPE_LATENCY + 10) @(posedge clk_i);
    if (mismatch_count == 0 && lod_expected_q.size() == 0) begin
      $display("screen_space_lod_classifier_top verification clean");
    end else begin
      $display("screen_space_lod_classifier_top verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
